// ===== design/mrd_pkg.sv =====
// Package for the MQTT receive deframer.
// Holds the parser phase, byte class, packet kind and error codes, and the result record.
// No dependencies.
package mrd_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int RSP_DATA_W       = 56;
   localparam int RSP_USER_W       = 6;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_TOPIC_HI = 3'd2,
      PH_TOPIC_LO = 3'd3,
      PH_TOPIC    = 3'd4,
      PH_PAYLOAD  = 3'd5,
      PH_BODY     = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CLS_HEADER    = 3'd0,
      CLS_LENGTH    = 3'd1,
      CLS_TOPIC_LEN = 3'd2,
      CLS_TOPIC     = 3'd3,
      CLS_PAYLOAD   = 3'd4,
      CLS_OTHER     = 3'd5
   } class_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_CONNACK = 3'd1,
      KIND_PUBLISH = 3'd2,
      KIND_SUBACK  = 3'd3,
      KIND_UNKNOWN = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_MALFORMED = 2'd1,
      ERR_UNKNOWN   = 2'd2,
      ERR_TOPIC     = 2'd3
   } error_type;

   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;
   localparam logic [3:0] TYPE_SUBACK  = 4'd9;

   typedef struct packed {
      logic [7:0]  byte_value;
      class_type   byte_class;
      kind_type    packet_kind;
      logic [27:0] body_length;
      logic [15:0] topic_size;
      error_type   error_code;
      logic        packet_end;
   } result_type;

endpackage

// ===== design/mrd_parser.sv =====
// Per-byte parser state and tagging logic of the MQTT receive deframer.
// Depends on mrd_pkg.
module mrd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         rx_byte,
   output mrd_pkg::result_type result
);
   import mrd_pkg::*;

   phase_type   phase_ff, phase_in;
   kind_type    kind_ff, kind_in;
   logic [27:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [27:0] left_ff, left_in;
   logic [15:0] topic_ff, topic_in;
   logic [15:0] tleft_ff, tleft_in;

   logic [27:0] group;
   logic [27:0] acc_sum;
   logic [27:0] left_dec;
   logic [15:0] tleft_dec;
   logic [15:0] topic_lo;
   logic        too_many;
   logic        topic_big;
   kind_type    hdr_kind;

   class_type   cls;
   error_type   err;
   logic        pkt_end;

   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    group = {21'd0, rx_byte[6:0]};
         2'd1:    group = {14'd0, rx_byte[6:0], 7'd0};
         2'd2:    group = {7'd0, rx_byte[6:0], 14'd0};
         default: group = {rx_byte[6:0], 21'd0};
      endcase
   end

   assign acc_sum   = acc_ff + group;
   assign left_dec  = left_ff - {27'd0, (left_ff != 28'd0)};
   assign tleft_dec = tleft_ff - {15'd0, (tleft_ff != 16'd0)};
   assign topic_lo  = topic_ff | {8'd0, rx_byte};
   assign too_many  = (cnt_ff >= 3'(MAX_LENGTH_BYTES));
   assign topic_big = ({12'd0, topic_lo} > left_dec);

   always_comb begin
      case (rx_byte[7:4])
         TYPE_CONNACK: hdr_kind = KIND_CONNACK;
         TYPE_PUBLISH: hdr_kind = KIND_PUBLISH;
         TYPE_SUBACK:  hdr_kind = KIND_SUBACK;
         default:      hdr_kind = KIND_UNKNOWN;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      topic_in = topic_ff;
      tleft_in = tleft_ff;
      case (phase_ff)
         PH_LENGTH: begin
            if (too_many) begin
               phase_in = PH_HEADER;
            end else begin
               acc_in = acc_sum;
               cnt_in = cnt_ff + 3'd1;
               if (!rx_byte[7]) begin
                  left_in = acc_sum;
                  if (acc_sum == 28'd0) begin
                     phase_in = PH_HEADER;
                  end else if (kind_ff == KIND_PUBLISH) begin
                     phase_in = PH_TOPIC_HI;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
         end
         PH_TOPIC_HI: begin
            topic_in = {rx_byte, 8'd0};
            left_in  = left_dec;
            phase_in = (left_dec == 28'd0) ? PH_HEADER : PH_TOPIC_LO;
         end
         PH_TOPIC_LO: begin
            topic_in = topic_lo;
            tleft_in = topic_lo;
            left_in  = left_dec;
            if (left_dec == 28'd0) begin
               phase_in = PH_HEADER;
            end else if (topic_big) begin
               phase_in = PH_BODY;
            end else if (topic_lo != 16'd0) begin
               phase_in = PH_TOPIC;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_TOPIC: begin
            tleft_in = tleft_dec;
            left_in  = left_dec;
            if (left_dec == 28'd0) begin
               phase_in = PH_HEADER;
            end else if (tleft_dec == 16'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD, PH_BODY: begin
            left_in = left_dec;
            if (left_dec == 28'd0) begin
               phase_in = PH_HEADER;
            end
         end
         default: begin
            kind_in  = hdr_kind;
            acc_in   = 28'd0;
            cnt_in   = 3'd0;
            left_in  = 28'd0;
            topic_in = 16'd0;
            tleft_in = 16'd0;
            phase_in = PH_LENGTH;
         end
      endcase
   end

   // outputs
   always_comb begin
      cls     = CLS_OTHER;
      err     = ERR_NONE;
      pkt_end = 1'b0;
      case (phase_ff)
         PH_LENGTH: begin
            cls = CLS_LENGTH;
            if (too_many) begin
               err     = ERR_MALFORMED;
               pkt_end = 1'b1;
            end else if (!rx_byte[7] && (acc_sum == 28'd0)) begin
               pkt_end = 1'b1;
               if (kind_ff == KIND_PUBLISH) begin
                  err = ERR_TOPIC;
               end
            end
         end
         PH_TOPIC_HI: begin
            cls = CLS_TOPIC_LEN;
            if (left_dec == 28'd0) begin
               err     = ERR_TOPIC;
               pkt_end = 1'b1;
            end
         end
         PH_TOPIC_LO: begin
            cls     = CLS_TOPIC_LEN;
            pkt_end = (left_dec == 28'd0);
            if (topic_big) begin
               err = ERR_TOPIC;
            end
         end
         PH_TOPIC: begin
            cls     = CLS_TOPIC;
            pkt_end = (left_dec == 28'd0);
         end
         PH_PAYLOAD: begin
            cls     = CLS_PAYLOAD;
            pkt_end = (left_dec == 28'd0);
         end
         PH_BODY: begin
            cls     = CLS_OTHER;
            pkt_end = (left_dec == 28'd0);
         end
         default: begin
            cls = CLS_HEADER;
            if (hdr_kind == KIND_UNKNOWN) begin
               err = ERR_UNKNOWN;
            end
         end
      endcase
   end

   assign result.byte_value  = rx_byte;
   assign result.byte_class  = cls;
   assign result.packet_kind = kind_in;
   assign result.body_length = acc_in;
   assign result.topic_size  = topic_in;
   assign result.error_code  = err;
   assign result.packet_end  = pkt_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         kind_ff  <= KIND_NONE;
         acc_ff   <= 28'd0;
         cnt_ff   <= 3'd0;
         left_ff  <= 28'd0;
         topic_ff <= 16'd0;
         tleft_ff <= 16'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         topic_ff <= topic_in;
         tleft_ff <= tleft_in;
      end
   end

endmodule

// ===== design/mqtt_receive_deframer.sv =====
// Top level of the MQTT receive deframer: input register, parser, result register.
// Depends on mrd_pkg and mrd_parser.
//
// Usage:
//   req channel carries one received byte per item in req_tdata.
//   rsp channel returns one item per byte: the byte with its class, the packet
//   kind, the decoded remaining length and topic length, an error code, and
//   rsp_tlast on the last byte of each packet.
//   A byte waits in the input register until the result register is free;
//   its result is then registered and shown on rsp_tvalid. Throughput is one
//   byte per cycle while rsp_tready stays high; the two registers form a
//   two-entry pipeline, so a byte is taken while a result waits on rsp_tready.
//   When the receiver stalls, the result register holds and the input
//   register fills; req_tready then drops until the result is taken.
//   Reset (synchronous, active high) empties both registers and returns the
//   parser to waiting for a header byte with all counts cleared.
//   A fifth length byte flags a malformed length and ends the packet; the
//   next byte is taken as a header. Unknown packet types still have their
//   length decoded and their body passed through as other bytes.
module mqtt_receive_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] rx_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] byte_value, [35:8] body_length, [51:36] topic_size,
   // [53:52] error_code, [55:54] zero
   output logic [mrd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [2:0] byte_class, [5:3] packet_kind
   output logic [mrd_pkg::RSP_USER_W-1:0]     rsp_tuser,
   output logic                               rsp_tlast   // packet_end
);
   import mrd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type step_result;
   logic       advance;
   logic       req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   mrd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'd0, out_ff.error_code, out_ff.topic_size,
                        out_ff.body_length, out_ff.byte_value};
   assign rsp_tuser  = {out_ff.packet_kind, out_ff.byte_class};
   assign rsp_tlast  = out_ff.packet_end;

`ifndef SYNTHESIS
   a_malformed_ends: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.error_code == ERR_MALFORMED)
      |-> out_ff.packet_end && (out_ff.byte_class == CLS_LENGTH))
      else $error("malformed length did not end packet on a length byte");

   a_unknown_on_header: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.error_code == ERR_UNKNOWN)
      |-> (out_ff.byte_class == CLS_HEADER))
      else $error("unknown type error off a header byte");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.packet_kind != KIND_NONE))
      else $error("result without a packet kind");

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.byte_class == CLS_HEADER)
      |-> (out_ff.body_length == 28'd0) && (out_ff.topic_size == 16'd0)
          && !out_ff.packet_end)
      else $error("header byte with stale length fields");

   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("pending input byte lost");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for mqtt_receive_deframer: streams received bytes in, checks each tagged byte out.
// A built-in byte-tagging predictor produces the expected item for every accepted byte.
// Depends on mrd_pkg and the deframer RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrd_pkg::*;

   localparam int LIMIT = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic rsp_tlast;

   mqtt_receive_deframer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0] byte_q [$];
   result_type tagged_q [$];
   int unsigned bytes_in = 0;
   int unsigned bytes_out = 0;
   int unsigned stim_count = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned stall_left = 0;
   bit stall_done = 1'b0;

   // parser state mirror
   phase_type st_phase = PH_HEADER;
   kind_type st_kind = KIND_NONE;
   logic [27:0] st_acc = '0;
   int unsigned st_nlen = 0;
   logic [27:0] st_left = '0;
   logic [15:0] st_topic = '0;
   logic [15:0] st_topic_left = '0;
   result_type tag_next;

   function automatic bit take_body_byte();
      if (st_left > 0) st_left = st_left - 1;
      if (st_left == 0) begin
         st_phase = PH_HEADER;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic tag_byte(input logic [7:0] b, output result_type r);
      class_type cls;
      error_type err;
      logic last;
      cls = CLS_OTHER;
      err = ERR_NONE;
      last = 1'b0;
      case (st_phase)
         PH_LENGTH: begin
            cls = CLS_LENGTH;
            if (st_nlen >= MAX_LENGTH_BYTES) begin
               err = ERR_MALFORMED;
               last = 1'b1;
               st_phase = PH_HEADER;
            end else begin
               st_acc = st_acc + (28'(b[6:0]) << (7 * st_nlen));
               st_nlen++;
               if (!b[7]) begin
                  st_left = st_acc;
                  if (st_left == 0) begin
                     last = 1'b1;
                     st_phase = PH_HEADER;
                     if (st_kind == KIND_PUBLISH) err = ERR_TOPIC;
                  end else begin
                     st_phase = (st_kind == KIND_PUBLISH) ? PH_TOPIC_HI : PH_BODY;
                  end
               end
            end
         end
         PH_TOPIC_HI: begin
            cls = CLS_TOPIC_LEN;
            st_topic = {b, 8'h00};
            st_phase = PH_TOPIC_LO;
            if (take_body_byte()) begin
               last = 1'b1;
               err = ERR_TOPIC;
            end
         end
         PH_TOPIC_LO: begin
            cls = CLS_TOPIC_LEN;
            st_topic = st_topic | {8'h00, b};
            st_topic_left = st_topic;
            if (st_left > 0) st_left = st_left - 1;
            if ({12'h000, st_topic} > st_left) begin
               err = ERR_TOPIC;
               st_phase = PH_BODY;
            end else begin
               st_phase = (st_topic_left > 0) ? PH_TOPIC : PH_PAYLOAD;
            end
            if (st_left == 0) begin
               last = 1'b1;
               st_phase = PH_HEADER;
            end
         end
         PH_TOPIC: begin
            cls = CLS_TOPIC;
            if (st_topic_left > 0) st_topic_left = st_topic_left - 1;
            if (st_topic_left == 0) st_phase = PH_PAYLOAD;
            if (take_body_byte()) last = 1'b1;
         end
         PH_PAYLOAD: begin
            cls = CLS_PAYLOAD;
            if (take_body_byte()) last = 1'b1;
         end
         PH_BODY: begin
            cls = CLS_OTHER;
            if (take_body_byte()) last = 1'b1;
         end
         default: begin
            cls = CLS_HEADER;
            case (b[7:4])
               TYPE_CONNACK: st_kind = KIND_CONNACK;
               TYPE_PUBLISH: st_kind = KIND_PUBLISH;
               TYPE_SUBACK:  st_kind = KIND_SUBACK;
               default: begin
                  st_kind = KIND_UNKNOWN;
                  err = ERR_UNKNOWN;
               end
            endcase
            st_acc = '0;
            st_nlen = 0;
            st_left = '0;
            st_topic = '0;
            st_topic_left = '0;
            st_phase = PH_LENGTH;
         end
      endcase
      r.byte_value = b;
      r.byte_class = cls;
      r.packet_kind = st_kind;
      r.body_length = st_acc;
      r.topic_size = st_topic;
      r.error_code = err;
      r.packet_end = last;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tag_byte(req_tdata, tag_next);
            tagged_q.push_back(tag_next);
            bytes_in++;
         end
         if (!req_tvalid || req_tready) begin
            if (byte_q.size() > 0 &&
                ((bytes_in >= 300 && bytes_in < 400) || $urandom_range(99) >= 25)) begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // receiver
   always @(posedge clock) begin
      result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (tagged_q.size() == 0) begin
               $error("unexpected item: byte_value %0d", rsp_tdata[7:0]);
               errors++;
            end else begin
               exp_r = tagged_q.pop_front();
               check_field("byte_value", 32'(exp_r.byte_value), 32'(rsp_tdata[7:0]));
               check_field("byte_class", 32'(exp_r.byte_class), 32'(rsp_tuser[2:0]));
               check_field("packet_kind", 32'(exp_r.packet_kind), 32'(rsp_tuser[5:3]));
               check_field("body_length", 32'(exp_r.body_length), 32'(rsp_tdata[35:8]));
               check_field("topic_size", 32'(exp_r.topic_size), 32'(rsp_tdata[51:36]));
               check_field("error_code", 32'(exp_r.error_code), 32'(rsp_tdata[53:52]));
               check_field("packet_end", 32'(exp_r.packet_end), 32'(rsp_tlast));
            end
            bytes_out++;
         end
         if (!stall_done && bytes_out == 150) begin
            stall_left = 80;
            stall_done = 1'b1;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (bytes_out >= 300 && bytes_out < 400) || $urandom_range(99) >= 25;
         end
      end
   end

   task automatic put(input logic [7:0] b);
      byte_q.push_back(b);
      stim_count++;
   endtask

   // one random packet, mostly well formed, some with broken length or topic
   task automatic add_packet();
      int unsigned sel, nib, blen, tlen, nmin, ngrp;
      logic [7:0] body [$];
      sel = $urandom_range(99);
      if (sel < 8) begin
         put(8'($urandom_range(255)));
         repeat (MAX_LENGTH_BYTES) put(8'($urandom_range(128, 255)));
         put(8'($urandom_range(255)));
         return;
      end
      case ($urandom_range(3))
         0: nib = TYPE_CONNACK;
         1: nib = TYPE_PUBLISH;
         2: nib = TYPE_SUBACK;
         default: begin
            do nib = $urandom_range(15);
            while (nib == TYPE_CONNACK || nib == TYPE_PUBLISH || nib == TYPE_SUBACK);
         end
      endcase
      put({nib[3:0], 4'($urandom_range(15))});
      if (nib == TYPE_PUBLISH) begin
         if ($urandom_range(9) == 0) begin
            tlen = $urandom_range(65535);
            blen = $urandom_range(6);
         end else begin
            tlen = $urandom_range(8);
            blen = 2 + tlen + $urandom_range(12);
         end
         body.push_back(tlen[15:8]);
         body.push_back(tlen[7:0]);
      end else begin
         blen = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(12);
      end
      while (body.size() < blen) body.push_back(8'($urandom_range(255)));
      nmin = (blen < 128) ? 1 : 2;
      ngrp = nmin;
      if ($urandom_range(2) == 0) ngrp = nmin + $urandom_range(MAX_LENGTH_BYTES - nmin);
      for (int i = 0; i < ngrp; i++) put({i < ngrp - 1, 7'(blen >> (7 * i))});
      for (int i = 0; i < blen; i++) put(body[i]);
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_tvalid || tagged_q.size() != 0) @(negedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      // connack
      put(8'h20); put(8'h01); put(8'h00);
      // publish with empty body
      put(8'h30); put(8'h00);
      // publish body ends inside the topic length
      put(8'h31); put(8'h01); put(8'hAB);
      // topic longer than body
      put(8'h3F); put(8'h03); put(8'hFF); put(8'hFF); put(8'h55);
      // normal publish: one topic byte, one payload byte
      put(8'h30); put(8'h04); put(8'h00); put(8'h01); put(8'h74); put(8'hFF);
      // suback with four-byte padded length
      put(8'h9A); put(8'h81); put(8'h80); put(8'h80); put(8'h00); put(8'h42);
      // unknown type, fifth length byte, full accumulator
      put(8'h05); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
      wait_drained();
      stim_count = 0;
      while (stim_count < 250) add_packet();
      wait_drained();
      while (stim_count < 500) add_packet();
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0 && tagged_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
